[rtl/core/code_buffer_label_backpatcher_top_assert.svh]
// Assertion macros for the code buffer label backpatcher
`ifndef CODE_BUFFER_LABEL_BACKPATCHER_TOP_ASSERT_SVH
`define CODE_BUFFER_LABEL_BACKPATCHER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CBL_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define CBL_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define CBL_ASSERT(name, cond, msg)
`define CBL_ASSERT_NEXT(name, pre, post, msg)
`endif
`endif

[rtl/core/cbl_pkg.sv]
// Shared types and codes for the code buffer label backpatcher
package cbl_pkg;

    localparam logic [2:0] CMD_APPEND   = 3'd0;
    localparam logic [2:0] CMD_CREATE   = 3'd1;
    localparam logic [2:0] CMD_MARK     = 3'd2;
    localparam logic [2:0] CMD_BRANCH   = 3'd3;
    localparam logic [2:0] CMD_RELATIVE = 3'd4;
    localparam logic [2:0] CMD_QUERY    = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_LABEL = 3'd1;
    localparam logic [2:0] ST_TABLE_FULL = 3'd2;
    localparam logic [2:0] ST_STORE_FULL = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] value;
        logic [3:0]  append_count;
        logic [5:0]  label_number;
        logic [4:0]  branch_field_bits;
        logic [4:0]  branch_field_shift;
        logic [31:0] opcode_bytes;
        logic [2:0]  opcode_count;
        logic [2:0]  displacement_width;
        logic [11:0] read_address;
    } cbl_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  new_label;
        logic [12:0] code_length;
        logic [7:0]  read_byte;
        logic [11:0] label_offset;
        logic        label_is_set;
    } cbl_result_t;

endpackage

[rtl/core/cbl_ram.sv]
// Single-port RAM with registered read data
module cbl_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [W-1:0]             wdata,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/core/cbl_patch_unit.sv]
// Shared offset unit: branch field insertion and relative displacement
module cbl_patch_unit #(
    parameter int LENW = 13,
    parameter int CAW  = 12
) (
    input  logic [LENW-1:0] target,
    input  logic [CAW-1:0]  site,
    input  logic [31:0]     word,
    input  logic [4:0]      field_bits,
    input  logic [4:0]      field_shift,
    input  logic [2:0]      width,
    output logic [31:0]     word_out,
    output logic [31:0]     disp,
    output logic            fits
);

    localparam int DW = LENW + 2;

    logic signed [DW-1:0] t_s;
    logic signed [DW-1:0] s_s;
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] dq;
    logic signed [DW-1:0] q;
    logic signed [DW-1:0] rel;
    logic [31:0]          q32;
    logic [31:0]          mask;
    logic [31:0]          fm;
    logic [31:0]          fv;

    assign t_s  = $signed(DW'(target));
    assign s_s  = $signed(DW'(site));
    assign d    = t_s - s_s;
    assign dq   = d + $signed(DW'(d[DW-1] ? 3 : 0));
    assign q    = dq >>> 2;
    assign q32  = 32'(q);
    assign mask = 32'((33'd1 << field_bits) - 33'd1);
    assign fm   = 32'({32'b0, mask} << field_shift);
    assign fv   = 32'({32'b0, q32 & mask} << field_shift);
    assign word_out = (word & ~fm) | fv;

    assign rel = t_s - (s_s + $signed(DW'(width)));

    always_comb
    begin
        case (width)
            3'd1:    fits = (rel >= -128) && (rel <= 127);
            3'd2:    fits = (rel >= -32768) && (rel <= 32767);
            3'd3:    fits = (rel >= -8388608) && (rel <= 8388607);
            default: fits = 1'b1;
        endcase
    end

    assign disp = fits ? 32'(rel) : 32'b0;

endmodule

[rtl/core/code_buffer_label_backpatcher_top.sv]
// Create/query: idle, decode, done. Append/emit: decode, byte writes, slot search if pending.
// Mark: decode, then a scan of all fixup slots; a branch patch reads 4 bytes and writes 4.
// The sequencer around the single code store port sets the rate; busy holds off start.
// One result per item, strobed by done for one cycle; the receiver cannot stall.
// Reset (async, active low) clears length, label count, mark bits and fixup live bits.
module code_buffer_label_backpatcher_top #(
    parameter int CODE_DEPTH  = 4096,
    parameter int LABEL_DEPTH = 64,
    parameter int FIXUP_DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  cbl_pkg::cbl_item_t  item,
    output logic                busy,
    output logic                done,
    output cbl_pkg::cbl_result_t result
);

    `include "code_buffer_label_backpatcher_top_assert.svh"

    localparam int CAW  = $clog2(CODE_DEPTH);
    localparam int LENW = $clog2(CODE_DEPTH + 1);
    localparam int LW   = $clog2(LABEL_DEPTH);
    localparam int LCW  = $clog2(LABEL_DEPTH + 1);
    localparam int FW   = $clog2(FIXUP_DEPTH);
    localparam int FCW  = $clog2(FIXUP_DEPTH + 1);
    localparam int FXW  = CAW + 20;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_DECODE   = 10'b0000000010,
        S_WRITE    = 10'b0000000100,
        S_FIND     = 10'b0000001000,
        S_SCAN_RD  = 10'b0000010000,
        S_SCAN_CHK = 10'b0000100000,
        S_BR_RD    = 10'b0001000000,
        S_BR_CAP   = 10'b0010000000,
        S_PATCH    = 10'b0100000000,
        S_DONE     = 10'b1000000000
    } state_t;

    state_t               state_reg, state_next;
    cbl_pkg::cbl_item_t   item_reg, item_next;
    logic [LENW-1:0]      len_reg, len_next;
    logic [LCW-1:0]       made_reg, made_next;
    logic [LABEL_DEPTH-1:0] marked_reg, marked_next;
    logic [FIXUP_DEPTH-1:0] live_reg, live_next;
    logic [FCW-1:0]       live_cnt_reg, live_cnt_next;
    logic [FCW-1:0]       ptr_reg, ptr_next;
    logic [63:0]          buf_reg, buf_next;
    logic [3:0]           nbytes_reg, nbytes_next;
    logic [CAW-1:0]       waddr_reg, waddr_next;
    logic                 grow_reg, grow_next;
    logic                 need_fix_reg, need_fix_next;
    logic                 in_mark_reg, in_mark_next;
    logic [CAW-1:0]       site_reg, site_next;
    logic [LENW-1:0]      target_reg, target_next;
    logic [31:0]          word_reg, word_next;
    logic [1:0]           bcnt_reg, bcnt_next;
    logic [4:0]           pbits_reg, pbits_next;
    logic [4:0]           pshift_reg, pshift_next;
    cbl_pkg::cbl_result_t res_reg, res_next;

    logic                 c_we;
    logic [CAW-1:0]       c_addr;
    logic [7:0]           c_q;
    logic                 l_we;
    logic [LW-1:0]        l_addr;
    logic [LENW-1:0]      l_q;
    logic                 f_we;
    logic [FXW-1:0]       f_wdata;
    logic [FXW-1:0]       f_q;

    logic [5:0]           fq_lab;
    logic                 fq_rel;
    logic [4:0]           fq_bits;
    logic [4:0]           fq_shift;
    logic [2:0]           fq_width;
    logic [CAW-1:0]       fq_site;

    logic [LENW-1:0]      pu_target;
    logic [CAW-1:0]       pu_site;
    logic [31:0]          pu_word;
    logic [4:0]           pu_bits;
    logic [4:0]           pu_shift;
    logic [2:0]           pu_width;
    logic [31:0]          pu_word_out;
    logic [31:0]          pu_disp;
    logic                 pu_fits;

    logic [LW-1:0]        lab_idx;
    logic                 lab_valid;
    logic                 lab_known;
    logic                 fix_full;
    logic [3:0]           cnt_sat;
    logic [2:0]           ocnt_sat;
    logic [2:0]           dw_sat;
    logic [31:0]          opc_masked;
    logic [63:0]          rel_bytes;

    assign fq_lab   = f_q[FXW-1 -: 6];
    assign fq_rel   = f_q[FXW-7];
    assign fq_bits  = f_q[FXW-8 -: 5];
    assign fq_shift = f_q[FXW-13 -: 5];
    assign fq_width = f_q[FXW-18 -: 3];
    assign fq_site  = f_q[CAW-1:0];

    assign lab_idx   = LW'(item_reg.label_number);
    assign lab_valid = 32'(item_reg.label_number) < 32'(made_reg);
    assign lab_known = lab_valid && marked_reg[lab_idx];
    assign fix_full  = live_cnt_reg == FCW'(FIXUP_DEPTH);
    assign cnt_sat   = (item_reg.append_count > 4'd8) ? 4'd8 : item_reg.append_count;
    assign ocnt_sat  = (item_reg.opcode_count > 3'd4) ? 3'd4 : item_reg.opcode_count;
    assign dw_sat    = (item_reg.displacement_width > 3'd4) ? 3'd4
                                                            : item_reg.displacement_width;
    assign opc_masked = item_reg.opcode_bytes
                      & 32'((64'd1 << {ocnt_sat, 3'b000}) - 64'd1);
    assign rel_bytes = {32'b0, opc_masked}
                     | ({32'b0, (lab_known ? pu_disp : 32'b0)} << {ocnt_sat, 3'b000});

    assign pu_target = (state_reg == S_DECODE) ? l_q : target_reg;
    assign pu_word   = (state_reg == S_DECODE) ? item_reg.value[31:0] : word_reg;
    assign pu_bits   = (state_reg == S_DECODE) ? item_reg.branch_field_bits : pbits_reg;
    assign pu_shift  = (state_reg == S_DECODE) ? item_reg.branch_field_shift : pshift_reg;
    assign pu_width  = (state_reg == S_DECODE) ? dw_sat : fq_width;

    always_comb
    begin
        if (state_reg == S_DECODE)
        begin
            if (item_reg.command == cbl_pkg::CMD_RELATIVE)
            begin
                pu_site = CAW'(len_reg + LENW'(ocnt_sat));
            end
            else
            begin
                pu_site = CAW'(len_reg);
            end
        end
        else if (state_reg == S_SCAN_CHK)
        begin
            pu_site = fq_site;
        end
        else
        begin
            pu_site = site_reg;
        end
    end

    cbl_patch_unit #(
        .LENW (LENW),
        .CAW  (CAW)
    ) u_patch (
        .target      (pu_target),
        .site        (pu_site),
        .word        (pu_word),
        .field_bits  (pu_bits),
        .field_shift (pu_shift),
        .width       (pu_width),
        .word_out    (pu_word_out),
        .disp        (pu_disp),
        .fits        (pu_fits)
    );

    assign c_we = state_reg == S_WRITE;
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            c_addr = CAW'(item.read_address);
        end
        else if (state_reg == S_BR_RD)
        begin
            c_addr = site_reg + CAW'(bcnt_reg);
        end
        else
        begin
            c_addr = waddr_reg;
        end
    end

    cbl_ram #(
        .W     (8),
        .DEPTH (CODE_DEPTH)
    ) u_code (
        .clk   (clk),
        .we    (c_we),
        .addr  (c_addr),
        .wdata (buf_reg[7:0]),
        .rdata (c_q)
    );

    assign l_addr = (state_reg == S_IDLE) ? LW'(item.label_number) : lab_idx;
    assign l_we   = (state_reg == S_DECODE) && (item_reg.command == cbl_pkg::CMD_MARK)
                 && lab_valid;

    cbl_ram #(
        .W     (LENW),
        .DEPTH (LABEL_DEPTH)
    ) u_label (
        .clk   (clk),
        .we    (l_we),
        .addr  (l_addr),
        .wdata (len_reg),
        .rdata (l_q)
    );

    assign f_we    = (state_reg == S_FIND) && !live_reg[ptr_reg[FW-1:0]];
    assign f_wdata = {item_reg.label_number,
                      item_reg.command == cbl_pkg::CMD_RELATIVE,
                      item_reg.branch_field_bits,
                      item_reg.branch_field_shift,
                      dw_sat,
                      site_reg};

    cbl_ram #(
        .W     (FXW),
        .DEPTH (FIXUP_DEPTH)
    ) u_fixup (
        .clk   (clk),
        .we    (f_we),
        .addr  (ptr_reg[FW-1:0]),
        .wdata (f_wdata),
        .rdata (f_q)
    );

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        len_next      = len_reg;
        made_next     = made_reg;
        marked_next   = marked_reg;
        live_next     = live_reg;
        live_cnt_next = live_cnt_reg;
        ptr_next      = ptr_reg;
        buf_next      = buf_reg;
        nbytes_next   = nbytes_reg;
        waddr_next    = waddr_reg;
        grow_next     = grow_reg;
        need_fix_next = need_fix_reg;
        in_mark_next  = in_mark_reg;
        site_next     = site_reg;
        target_next   = target_reg;
        word_next     = word_reg;
        bcnt_next     = bcnt_reg;
        pbits_next    = pbits_reg;
        pshift_next   = pshift_reg;
        res_next      = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    res_next   = '0;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next   = S_DONE;
                in_mark_next = 1'b0;
                waddr_next   = CAW'(len_reg);
                grow_next    = 1'b1;
                ptr_next     = '0;
                case (item_reg.command)
                    cbl_pkg::CMD_APPEND:
                    begin
                        if (32'(len_reg) + 32'(cnt_sat) > 32'(CODE_DEPTH))
                        begin
                            res_next.status = cbl_pkg::ST_STORE_FULL;
                        end
                        else if (cnt_sat != 4'd0)
                        begin
                            buf_next      = item_reg.value;
                            nbytes_next   = cnt_sat;
                            need_fix_next = 1'b0;
                            state_next    = S_WRITE;
                        end
                    end

                    cbl_pkg::CMD_CREATE:
                    begin
                        if (32'(made_reg) >= 32'(LABEL_DEPTH))
                        begin
                            res_next.status = cbl_pkg::ST_TABLE_FULL;
                        end
                        else
                        begin
                            res_next.new_label           = 6'(made_reg);
                            marked_next[LW'(made_reg)]  = 1'b0;
                            made_next                    = made_reg + LCW'(1);
                        end
                    end

                    cbl_pkg::CMD_MARK:
                    begin
                        if (!lab_valid)
                        begin
                            res_next.status = cbl_pkg::ST_BAD_LABEL;
                        end
                        else
                        begin
                            marked_next[lab_idx] = 1'b1;
                            target_next          = len_reg;
                            in_mark_next         = 1'b1;
                            state_next           = S_SCAN_RD;
                        end
                    end

                    cbl_pkg::CMD_BRANCH:
                    begin
                        if (32'(len_reg) + 32'd4 > 32'(CODE_DEPTH))
                        begin
                            res_next.status = cbl_pkg::ST_STORE_FULL;
                        end
                        else if (lab_valid && !lab_known && fix_full)
                        begin
                            res_next.status = cbl_pkg::ST_TABLE_FULL;
                        end
                        else
                        begin
                            buf_next      = {32'b0, lab_known ? pu_word_out
                                                              : item_reg.value[31:0]};
                            nbytes_next   = 4'd4;
                            site_next     = CAW'(len_reg);
                            need_fix_next = lab_valid && !lab_known;
                            if (!lab_valid)
                            begin
                                res_next.status = cbl_pkg::ST_BAD_LABEL;
                            end
                            state_next = S_WRITE;
                        end
                    end

                    cbl_pkg::CMD_RELATIVE:
                    begin
                        if (ocnt_sat == 3'd0 || dw_sat == 3'd0)
                        begin
                            res_next.status = cbl_pkg::ST_OK;
                        end
                        else if (32'(len_reg) + 32'(ocnt_sat) + 32'(dw_sat)
                                 > 32'(CODE_DEPTH))
                        begin
                            res_next.status = cbl_pkg::ST_STORE_FULL;
                        end
                        else if (lab_valid && !lab_known && fix_full)
                        begin
                            res_next.status = cbl_pkg::ST_TABLE_FULL;
                        end
                        else
                        begin
                            buf_next      = rel_bytes;
                            nbytes_next   = 4'(ocnt_sat) + 4'(dw_sat);
                            site_next     = pu_site;
                            need_fix_next = lab_valid && !lab_known;
                            if (!lab_valid)
                            begin
                                res_next.status = cbl_pkg::ST_BAD_LABEL;
                            end
                            else if (lab_known && !pu_fits)
                            begin
                                res_next.status = cbl_pkg::ST_RANGE;
                            end
                            state_next = S_WRITE;
                        end
                    end

                    cbl_pkg::CMD_QUERY:
                    begin
                        if (32'(item_reg.read_address) < 32'(len_reg))
                        begin
                            res_next.read_byte = c_q;
                        end
                        if (!lab_valid)
                        begin
                            res_next.status = cbl_pkg::ST_BAD_LABEL;
                        end
                        else if (marked_reg[lab_idx])
                        begin
                            res_next.label_offset = 12'(l_q);
                            res_next.label_is_set = 1'b1;
                        end
                    end

                    default:
                    begin
                        res_next.status = cbl_pkg::ST_OK;
                    end
                endcase
            end

            S_WRITE:
            begin
                buf_next    = {8'b0, buf_reg[63:8]};
                waddr_next  = waddr_reg + CAW'(1);
                nbytes_next = nbytes_reg - 4'd1;
                if (grow_reg)
                begin
                    len_next = len_reg + LENW'(1);
                end
                if (nbytes_reg == 4'd1)
                begin
                    if (in_mark_reg)
                    begin
                        ptr_next   = ptr_reg + FCW'(1);
                        state_next = S_SCAN_RD;
                    end
                    else if (need_fix_reg)
                    begin
                        ptr_next   = '0;
                        state_next = S_FIND;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_FIND:
            begin
                if (!live_reg[ptr_reg[FW-1:0]])
                begin
                    live_next[ptr_reg[FW-1:0]] = 1'b1;
                    live_cnt_next              = live_cnt_reg + FCW'(1);
                    state_next                 = S_DONE;
                end
                else
                begin
                    ptr_next = ptr_reg + FCW'(1);
                end
            end

            S_SCAN_RD:
            begin
                if (ptr_reg == FCW'(FIXUP_DEPTH))
                begin
                    state_next = S_DONE;
                end
                else if (live_reg[ptr_reg[FW-1:0]])
                begin
                    state_next = S_SCAN_CHK;
                end
                else
                begin
                    ptr_next = ptr_reg + FCW'(1);
                end
            end

            S_SCAN_CHK:
            begin
                if (fq_lab != item_reg.label_number)
                begin
                    ptr_next   = ptr_reg + FCW'(1);
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    live_next[ptr_reg[FW-1:0]] = 1'b0;
                    live_cnt_next              = live_cnt_reg - FCW'(1);
                    site_next                  = fq_site;
                    if (fq_rel)
                    begin
                        if (pu_fits)
                        begin
                            buf_next    = {32'b0, pu_disp};
                            nbytes_next = 4'(fq_width);
                            waddr_next  = fq_site;
                            grow_next   = 1'b0;
                            state_next  = S_WRITE;
                        end
                        else
                        begin
                            res_next.status = cbl_pkg::ST_RANGE;
                            ptr_next        = ptr_reg + FCW'(1);
                            state_next      = S_SCAN_RD;
                        end
                    end
                    else
                    begin
                        pbits_next  = fq_bits;
                        pshift_next = fq_shift;
                        bcnt_next   = 2'd0;
                        state_next  = S_BR_RD;
                    end
                end
            end

            S_BR_RD:
            begin
                state_next = S_BR_CAP;
            end

            S_BR_CAP:
            begin
                word_next = {c_q, word_reg[31:8]};
                bcnt_next = bcnt_reg + 2'd1;
                if (bcnt_reg == 2'd3)
                begin
                    state_next = S_PATCH;
                end
                else
                begin
                    state_next = S_BR_RD;
                end
            end

            S_PATCH:
            begin
                buf_next    = {32'b0, pu_word_out};
                nbytes_next = 4'd4;
                waddr_next  = site_reg;
                grow_next   = 1'b0;
                state_next  = S_WRITE;
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            len_reg      <= '0;
            made_reg     <= '0;
            marked_reg   <= '0;
            live_reg     <= '0;
            live_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            made_reg     <= made_next;
            marked_reg   <= marked_next;
            live_reg     <= live_next;
            live_cnt_reg <= live_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        ptr_reg      <= ptr_next;
        buf_reg      <= buf_next;
        nbytes_reg   <= nbytes_next;
        waddr_reg    <= waddr_next;
        grow_reg     <= grow_next;
        need_fix_reg <= need_fix_next;
        in_mark_reg  <= in_mark_next;
        site_reg     <= site_next;
        target_reg   <= target_next;
        word_reg     <= word_next;
        bcnt_reg     <= bcnt_next;
        pbits_reg    <= pbits_next;
        pshift_reg   <= pshift_next;
        res_reg      <= res_next;
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_DONE;

    assign result.status       = res_reg.status;
    assign result.new_label    = res_reg.new_label;
    assign result.code_length  = 13'(len_reg);
    assign result.read_byte    = res_reg.read_byte;
    assign result.label_offset = res_reg.label_offset;
    assign result.label_is_set = res_reg.label_is_set;

    `CBL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
    `CBL_ASSERT_NEXT(a_done_release, done, !busy, "busy held after result beat")
    `CBL_ASSERT(a_live_count, 32'(live_cnt_reg) == $countones(live_reg), "fixup count mismatch")
    `CBL_ASSERT(a_len_bound, 32'(len_reg) <= 32'(CODE_DEPTH), "code length beyond store")

endmodule

[test/code_buffer_label_backpatcher_top_tb.sv]
// Self-checking testbench for the code buffer label backpatcher: directed and random beats vs. a predictor
`timescale 1ns / 100ps
module code_buffer_label_backpatcher_top_tb;

    localparam int CODE_DEPTH  = 4096;
    localparam int LABEL_DEPTH = 64;
    localparam int FIXUP_DEPTH = 64;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    cbl_pkg::cbl_item_t   item;
    logic                 busy;
    logic                 done;
    cbl_pkg::cbl_result_t result;

    code_buffer_label_backpatcher_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item),
        .busy(busy), .done(done), .result(result)
    );

    always
    begin
        clk = 1'b0; #4;
        clk = 1'b1; #4;
    end

    // predictor state
    logic [7:0]  code_mem [CODE_DEPTH];
    int          code_len;
    int          labels_made;
    int          label_pos [LABEL_DEPTH];
    bit          label_set [LABEL_DEPTH];
    int          fix_label [FIXUP_DEPTH];
    int          fix_site [FIXUP_DEPTH];
    bit          fix_rel [FIXUP_DEPTH];
    int          fix_bits [FIXUP_DEPTH];
    int          fix_shift [FIXUP_DEPTH];
    int          fix_width [FIXUP_DEPTH];
    bit          fix_live [FIXUP_DEPTH];

    cbl_pkg::cbl_item_t   pending_beats [$];
    cbl_pkg::cbl_result_t expected_results [$];
    int          gap_left;
    int          mismatches;
    int          cycles;
    int          gen_labels;

    function automatic void store_byte(int a, logic [7:0] b);
        if (a < CODE_DEPTH)
            code_mem[a] = b;
    endfunction

    function automatic logic [7:0] load_byte(int a);
        return (a < CODE_DEPTH) ? code_mem[a] : 8'h00;
    endfunction

    function automatic logic [31:0] insert_field(logic [31:0] word, longint target,
                                                 longint site, int bits, int shift);
        longint      q;
        logic [63:0] mask;
        logic [31:0] fm;
        logic [31:0] fv;
        q    = (target - site) / 4;
        mask = (64'd1 << bits) - 64'd1;
        fm   = 32'(mask << shift);
        fv   = 32'((64'(q) & mask) << shift);
        return (word & ~fm) | fv;
    endfunction

    function automatic bit write_disp(int site, int width, longint target);
        longint rel;
        longint lim;
        rel = target - (longint'(site) + width);
        lim = longint'(1) << (width * 8 - 1);
        if (rel < -lim || rel > lim - 1)
            return 1'b0;
        for (int b = 0; b < width; b++)
            store_byte(site + b, 8'(rel >>> (8 * b)));
        return 1'b1;
    endfunction

    function automatic int find_free_slot();
        for (int i = 0; i < FIXUP_DEPTH; i++)
            if (!fix_live[i])
                return i;
        return -1;
    endfunction

    function automatic cbl_pkg::cbl_result_t predict_result(cbl_pkg::cbl_item_t it);
        cbl_pkg::cbl_result_t r;
        int          lab;
        bit          valid;
        bit          known;
        int          slot;
        int          site;
        int          cnt;
        int          ocnt;
        int          dw;
        logic [31:0] w;
        r     = '0;
        lab   = it.label_number;
        valid = lab < labels_made;
        known = valid && label_set[lab];
        case (it.command)
            cbl_pkg::CMD_APPEND:
            begin
                cnt = (it.append_count > 8) ? 8 : it.append_count;
                if (code_len + cnt > CODE_DEPTH)
                    r.status = cbl_pkg::ST_STORE_FULL;
                else
                    for (int i = 0; i < cnt; i++)
                    begin
                        store_byte(code_len, it.value[8*i +: 8]);
                        code_len++;
                    end
            end
            cbl_pkg::CMD_CREATE:
            begin
                if (labels_made >= LABEL_DEPTH)
                    r.status = cbl_pkg::ST_TABLE_FULL;
                else
                begin
                    r.new_label = 6'(labels_made);
                    label_pos[labels_made] = 0;
                    label_set[labels_made] = 1'b0;
                    labels_made++;
                end
            end
            cbl_pkg::CMD_MARK:
            begin
                if (!valid)
                    r.status = cbl_pkg::ST_BAD_LABEL;
                else
                begin
                    label_pos[lab] = code_len;
                    label_set[lab] = 1'b1;
                    for (int i = 0; i < FIXUP_DEPTH; i++)
                    begin
                        if (!fix_live[i] || fix_label[i] != lab)
                            continue;
                        fix_live[i] = 1'b0;
                        site = fix_site[i];
                        if (fix_rel[i])
                        begin
                            if (!write_disp(site, fix_width[i], code_len))
                                r.status = cbl_pkg::ST_RANGE;
                        end
                        else
                        begin
                            w = {load_byte(site + 3), load_byte(site + 2),
                                 load_byte(site + 1), load_byte(site)};
                            w = insert_field(w, code_len, site, fix_bits[i], fix_shift[i]);
                            for (int b = 0; b < 4; b++)
                                store_byte(site + b, w[8*b +: 8]);
                        end
                    end
                end
            end
            cbl_pkg::CMD_BRANCH:
            begin
                slot = (valid && !known) ? find_free_slot() : 0;
                site = code_len;
                w    = it.value[31:0];
                if (code_len + 4 > CODE_DEPTH)
                    r.status = cbl_pkg::ST_STORE_FULL;
                else if (slot < 0)
                    r.status = cbl_pkg::ST_TABLE_FULL;
                else
                begin
                    if (known)
                        w = insert_field(w, label_pos[lab], site,
                                         it.branch_field_bits, it.branch_field_shift);
                    for (int b = 0; b < 4; b++)
                    begin
                        store_byte(code_len, w[8*b +: 8]);
                        code_len++;
                    end
                    if (!valid)
                        r.status = cbl_pkg::ST_BAD_LABEL;
                    else if (!known)
                    begin
                        fix_live[slot]  = 1'b1;
                        fix_label[slot] = lab;
                        fix_site[slot]  = site;
                        fix_rel[slot]   = 1'b0;
                        fix_bits[slot]  = it.branch_field_bits;
                        fix_shift[slot] = it.branch_field_shift;
                        fix_width[slot] = 0;
                    end
                end
            end
            cbl_pkg::CMD_RELATIVE:
            begin
                ocnt = (it.opcode_count > 4) ? 4 : it.opcode_count;
                dw   = (it.displacement_width > 4) ? 4 : it.displacement_width;
                if (ocnt != 0 && dw != 0)
                begin
                    slot = (valid && !known) ? find_free_slot() : 0;
                    if (code_len + ocnt + dw > CODE_DEPTH)
                        r.status = cbl_pkg::ST_STORE_FULL;
                    else if (slot < 0)
                        r.status = cbl_pkg::ST_TABLE_FULL;
                    else
                    begin
                        for (int i = 0; i < ocnt; i++)
                        begin
                            store_byte(code_len, it.opcode_bytes[8*i +: 8]);
                            code_len++;
                        end
                        site = code_len;
                        for (int i = 0; i < dw; i++)
                        begin
                            store_byte(code_len, 8'h00);
                            code_len++;
                        end
                        if (!valid)
                            r.status = cbl_pkg::ST_BAD_LABEL;
                        else if (known)
                        begin
                            if (!write_disp(site, dw, label_pos[lab]))
                                r.status = cbl_pkg::ST_RANGE;
                        end
                        else
                        begin
                            fix_live[slot]  = 1'b1;
                            fix_label[slot] = lab;
                            fix_site[slot]  = site;
                            fix_rel[slot]   = 1'b1;
                            fix_bits[slot]  = 0;
                            fix_shift[slot] = 0;
                            fix_width[slot] = dw;
                        end
                    end
                end
            end
            cbl_pkg::CMD_QUERY:
            begin
                if (it.read_address < code_len)
                    r.read_byte = load_byte(it.read_address);
                if (!valid)
                    r.status = cbl_pkg::ST_BAD_LABEL;
                else if (label_set[lab])
                begin
                    r.label_offset = 12'(label_pos[lab]);
                    r.label_is_set = 1'b1;
                end
            end
            default: ;
        endcase
        r.code_length = 13'(code_len);
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    function automatic cbl_pkg::cbl_item_t make_beat(logic [2:0] cmd, logic [5:0] lab);
        cbl_pkg::cbl_item_t it;
        it.command            = cmd;
        it.value              = {$urandom, $urandom};
        it.append_count       = ($urandom_range(0, 9) == 0) ? 4'($urandom)
                                                            : 4'($urandom_range(1, 8));
        it.label_number       = lab;
        it.branch_field_bits  = 5'($urandom);
        it.branch_field_shift = 5'($urandom);
        it.opcode_bytes       = $urandom;
        it.opcode_count       = ($urandom_range(0, 9) == 0) ? 3'($urandom)
                                                            : 3'($urandom_range(1, 4));
        it.displacement_width = ($urandom_range(0, 9) == 0) ? 3'($urandom)
                                                            : 3'($urandom_range(1, 4));
        it.read_address       = 12'($urandom);
        return it;
    endfunction

    task automatic queue_beat(cbl_pkg::cbl_item_t it);
        if (it.command == cbl_pkg::CMD_CREATE && gen_labels < LABEL_DEPTH)
            gen_labels++;
        pending_beats.push_back(it);
    endtask

    function automatic logic [5:0] pick_label();
        if (gen_labels == 0 || $urandom_range(0, 9) == 0)
            return 6'($urandom);
        return 6'($urandom_range(0, gen_labels - 1));
    endfunction

    function automatic logic [2:0] pick_command();
        int p;
        p = $urandom_range(0, 99);
        if (p < 25) return cbl_pkg::CMD_APPEND;
        if (p < 35) return cbl_pkg::CMD_CREATE;
        if (p < 47) return cbl_pkg::CMD_MARK;
        if (p < 65) return cbl_pkg::CMD_BRANCH;
        if (p < 82) return cbl_pkg::CMD_RELATIVE;
        if (p < 98) return cbl_pkg::CMD_QUERY;
        return (p == 98) ? CMD_SPARE6 : CMD_SPARE7;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            item     <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_results.push_back(predict_result(item));
            if (!start || !busy)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end
                else if (pending_beats.size() != 0)
                begin
                    item     <= pending_beats.pop_front();
                    start    <= 1'b1;
                    gap_left <= pick_gap();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", result);
            end
            else
            begin
                cbl_pkg::cbl_result_t exp_r;
                exp_r = expected_results.pop_front();
                if (result.status !== exp_r.status || result.new_label !== exp_r.new_label ||
                    result.code_length !== exp_r.code_length ||
                    result.read_byte !== exp_r.read_byte ||
                    result.label_offset !== exp_r.label_offset ||
                    result.label_is_set !== exp_r.label_is_set)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, result);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        cbl_pkg::cbl_item_t it;
        code_len    = 0;
        labels_made = 0;
        gen_labels  = 0;
        mismatches  = 0;
        cycles      = 0;
        for (int i = 0; i < LABEL_DEPTH; i++)
            label_set[i] = 1'b0;
        for (int i = 0; i < FIXUP_DEPTH; i++)
            fix_live[i] = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        item  = '0;

        // directed
        it = make_beat(cbl_pkg::CMD_QUERY, 6'd0);          queue_beat(it);
        it = make_beat(cbl_pkg::CMD_APPEND, 6'd0);
        it.value = '1; it.append_count = 4'd8;             queue_beat(it);
        it = make_beat(cbl_pkg::CMD_APPEND, 6'd0);
        it.append_count = 4'd0;                            queue_beat(it);
        it = make_beat(cbl_pkg::CMD_APPEND, 6'd0);
        it.value = '0; it.append_count = 4'd15;            queue_beat(it);
        it = make_beat(cbl_pkg::CMD_MARK, 6'd0);           queue_beat(it);
        it = make_beat(cbl_pkg::CMD_CREATE, 6'd0);         queue_beat(it);
        it = make_beat(cbl_pkg::CMD_MARK, 6'd0);           queue_beat(it);
        it = make_beat(cbl_pkg::CMD_CREATE, 6'd0);         queue_beat(it);
        it = make_beat(cbl_pkg::CMD_BRANCH, 6'd1);
        it.branch_field_bits = 5'd31; it.branch_field_shift = 5'd0; queue_beat(it);
        it = make_beat(cbl_pkg::CMD_RELATIVE, 6'd1);
        it.opcode_count = 3'd1; it.displacement_width = 3'd1; queue_beat(it);
        it = make_beat(cbl_pkg::CMD_RELATIVE, 6'd1);
        it.opcode_count = 3'd7; it.displacement_width = 3'd7; queue_beat(it);
        it = make_beat(cbl_pkg::CMD_RELATIVE, 6'd1);
        it.opcode_count = 3'd0;                            queue_beat(it);
        it = make_beat(CMD_SPARE6, 6'd1);                  queue_beat(it);
        it = make_beat(CMD_SPARE7, 6'd1);                  queue_beat(it);
        it = make_beat(cbl_pkg::CMD_MARK, 6'd1);           queue_beat(it);
        it = make_beat(cbl_pkg::CMD_BRANCH, 6'd0);
        it.branch_field_bits = 5'd1; it.branch_field_shift = 5'd31; queue_beat(it);
        it = make_beat(cbl_pkg::CMD_BRANCH, 6'd0);
        it.branch_field_bits = 5'd0;                       queue_beat(it);
        it = make_beat(cbl_pkg::CMD_RELATIVE, 6'd0);       queue_beat(it);
        it = make_beat(cbl_pkg::CMD_BRANCH, 6'd63);        queue_beat(it);
        it = make_beat(cbl_pkg::CMD_RELATIVE, 6'd63);      queue_beat(it);
        it = make_beat(cbl_pkg::CMD_QUERY, 6'd1);
        it.read_address = 12'd0;                           queue_beat(it);
        it = make_beat(cbl_pkg::CMD_QUERY, 6'd1);
        it.read_address = 12'd4095;                        queue_beat(it);
        it = make_beat(cbl_pkg::CMD_MARK, 6'd0);           queue_beat(it);

        // fixup table overflow, then out-of-range patch on mark
        it = make_beat(cbl_pkg::CMD_CREATE, 6'd0);         queue_beat(it);
        it = make_beat(cbl_pkg::CMD_RELATIVE, 6'd2);
        it.opcode_count = 3'd1; it.displacement_width = 3'd1; queue_beat(it);
        for (int i = 0; i < 66; i++)
        begin
            it = make_beat(cbl_pkg::CMD_BRANCH, 6'd2);     queue_beat(it);
        end
        it = make_beat(cbl_pkg::CMD_MARK, 6'd2);           queue_beat(it);

        // random
        for (int i = 0; i < 120; i++)
        begin
            it = make_beat(pick_command(), pick_label());
            queue_beat(it);
        end

        // fill the store, then hit it while full
        for (int i = 0; i < 500; i++)
        begin
            if ($urandom_range(0, 24) == 0)
                it = make_beat(pick_command(), pick_label());
            else
            begin
                it = make_beat(cbl_pkg::CMD_APPEND, 6'd0);
                it.append_count = 4'd8;
            end
            queue_beat(it);
        end
        for (int i = 0; i < 30; i++)
        begin
            it = make_beat(pick_command(), pick_label());
            queue_beat(it);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || start || expected_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
